[src/bma_pkg.sv]
package bma_pkg;

    localparam int DEF_MAP_BYTES = 512;
    localparam int DEF_NUM_MAPS  = 2;
    localparam int BYTE_W        = 8;
    localparam int OFF_W         = 3;
    localparam int INDEX_W       = 12;
    localparam int LIMIT_W       = 13;
    localparam int INDEX_SPAN    = 4096;

    typedef enum logic [1:0] {
        CMD_TEST  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_ALLOC = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK            = 3'd0,
        STAT_RANGE         = 3'd1,
        STAT_ALREADY_SET   = 3'd2,
        STAT_ALREADY_CLEAR = 3'd3,
        STAT_NO_FREE       = 3'd4
    } status_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_LOOK = 1'b1
    } fsm_t;

endpackage

[src/bma_if.sv]
interface bma_req_if;
    logic                            valid;
    logic                            ready;
    bma_pkg::cmd_t                   command;
    logic                            map_select;
    logic [bma_pkg::INDEX_W-1:0]     bit_index;
    logic [bma_pkg::LIMIT_W-1:0]     bit_limit;

    modport source (output valid, command, map_select, bit_index, bit_limit, input ready);
    modport sink   (input valid, command, map_select, bit_index, bit_limit, output ready);
endinterface

interface bma_rsp_if;
    logic                            valid;
    logic                            ready;
    bma_pkg::status_t                status;
    logic                            bit_state;
    logic [bma_pkg::INDEX_W-1:0]     found_index;

    modport source (output valid, status, bit_state, found_index, input ready);
    modport sink   (input valid, status, bit_state, found_index, output ready);
endinterface

[src/bma_store.sv]
module bma_store #(
    parameter int DEPTH = bma_pkg::DEF_NUM_MAPS * bma_pkg::DEF_MAP_BYTES,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [bma_pkg::BYTE_W-1:0] rd_data,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [bma_pkg::BYTE_W-1:0] wr_data,
    output logic                       clearing
);
    import bma_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              clearing_reg;
    logic              clearing_next;

    // zero sweep after reset, one byte per cycle
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clearing_reg <= clearing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

[src/bitmap_allocator_unit.sv]
// Test, set and clear: the store byte is read on acceptance, and in FSM_LOOK the result word is registered.
// Allocate: the lookup reads one bitmap byte per cycle through the single read port of the store,
//   from the start byte until a free bit is found or the limit is reached, and then registers
//   the result. A result held in the output register stalls the lookup.
// A new word is taken only once the previous result is loaded into the output register.
// After rst_n all NUM_MAPS * MAP_BYTES bytes (1024 by default) of the store are swept to zero, req.ready low.
module bitmap_allocator_unit #(
    parameter int MAP_BYTES = bma_pkg::DEF_MAP_BYTES,
    parameter int NUM_MAPS  = bma_pkg::DEF_NUM_MAPS
) (
    input  logic          clk,
    input  logic          rst_n,
    bma_req_if.sink       req,
    bma_rsp_if.source     rsp
);
    import bma_pkg::*;

    localparam int DEPTH    = NUM_MAPS * MAP_BYTES;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MAP_BITS = MAP_BYTES * BYTE_W;
    localparam int SPAN_END = (MAP_BITS < INDEX_SPAN) ? MAP_BITS : INDEX_SPAN;
    localparam int BYTE_IW  = INDEX_W - OFF_W;

    fsm_t                state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    status_t             pre_reg, pre_next;
    logic [OFF_W-1:0]    off_reg, off_next;
    logic [LIMIT_W-1:0]  end_reg, end_next;
    logic [BYTE_IW-1:0]  byte_reg, byte_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                first_reg, first_next;

    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic                out_bit_reg, out_bit_next;
    logic [INDEX_W-1:0]  out_found_reg, out_found_next;

    logic                accept;
    logic                out_free;
    logic                clearing;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [BYTE_W-1:0]   rd_data;
    logic                wr_en;
    logic [BYTE_W-1:0]   wr_data;

    logic [LIMIT_W-1:0]  req_end;
    logic                map_ok;
    logic                idx_ok;
    logic [ADDR_W-1:0]   map_base;
    logic [BYTE_W-1:0]   bit_mask;
    logic                cur_bit;
    logic [BYTE_W-1:0]   lo_mask;
    logic [BYTE_W-1:0]   hi_mask;
    logic [BYTE_W-1:0]   cand;
    logic [OFF_W-1:0]    pick;
    logic [BYTE_IW:0]    next_byte;
    logic                more;

    bma_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (addr_reg),
        .wr_data  (wr_data),
        .clearing (clearing)
    );

    assign req.ready = (state_reg == FSM_IDLE) && !clearing;
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.bit_state   = out_bit_reg;
    assign rsp.found_index = out_found_reg;

    // request decode
    always_comb
    begin
        req_end  = (req.bit_limit < LIMIT_W'(SPAN_END)) ? req.bit_limit : LIMIT_W'(SPAN_END);
        map_ok   = 32'(req.map_select) < NUM_MAPS;
        idx_ok   = ({1'b0, req.bit_index} < req.bit_limit) && (32'(req.bit_index) < MAP_BITS);
        map_base = req.map_select ? ADDR_W'(MAP_BYTES) : '0;
    end

    // scan byte evaluation
    always_comb
    begin
        bit_mask = BYTE_W'(1) << off_reg;
        cur_bit  = rd_data[off_reg];
        lo_mask  = first_reg ? (8'hFF << off_reg) : 8'hFF;
        for (int k = 0; k < BYTE_W; k++)
        begin
            hi_mask[k] = {1'b0, byte_reg, OFF_W'(k)} < end_reg;
        end
        cand = ~rd_data & lo_mask & hi_mask;
        pick = '0;
        for (int k = BYTE_W - 1; k >= 0; k--)
        begin
            if (cand[k])
            begin
                pick = OFF_W'(k);
            end
        end
        next_byte = {1'b0, byte_reg} + 1'b1;
        more      = {next_byte, {OFF_W{1'b0}}} < end_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        pre_next        = pre_reg;
        off_next        = off_reg;
        end_next        = end_reg;
        byte_next       = byte_reg;
        addr_next       = addr_reg;
        first_next      = first_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_bit_next    = out_bit_reg;
        out_found_next  = out_found_reg;
        rd_en           = 1'b0;
        rd_addr         = addr_reg;
        wr_en           = 1'b0;
        wr_data         = rd_data;

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = req.command;
                    off_next   = req.bit_index[OFF_W-1:0];
                    byte_next  = req.bit_index[INDEX_W-1:OFF_W];
                    end_next   = req_end;
                    first_next = 1'b1;
                    if (!map_ok)
                    begin
                        pre_next = STAT_RANGE;
                    end
                    else if (req.command == CMD_ALLOC)
                    begin
                        pre_next = ({1'b0, req.bit_index} < req_end) ? STAT_OK : STAT_NO_FREE;
                    end
                    else
                    begin
                        pre_next = idx_ok ? STAT_OK : STAT_RANGE;
                    end
                    addr_next  = map_base + ADDR_W'(req.bit_index[INDEX_W-1:OFF_W]);
                    rd_addr    = addr_next;
                    rd_en      = (pre_next == STAT_OK);
                    state_next = FSM_LOOK;
                end
            end

            FSM_LOOK:
            begin
                if (out_free)
                begin
                    out_bit_next   = 1'b0;
                    out_found_next = '0;
                    if (pre_reg != STAT_OK)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = pre_reg;
                        state_next      = FSM_IDLE;
                    end
                    else
                    begin
                        unique case (cmd_reg)
                            CMD_TEST:
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = STAT_OK;
                                out_bit_next    = cur_bit;
                                state_next      = FSM_IDLE;
                            end
                            CMD_SET:
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = cur_bit ? STAT_ALREADY_SET : STAT_OK;
                                wr_en           = !cur_bit;
                                wr_data         = rd_data | bit_mask;
                                state_next      = FSM_IDLE;
                            end
                            CMD_CLEAR:
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = cur_bit ? STAT_OK : STAT_ALREADY_CLEAR;
                                wr_en           = cur_bit;
                                wr_data         = rd_data & ~bit_mask;
                                state_next      = FSM_IDLE;
                            end
                            CMD_ALLOC:
                            begin
                                if (cand != '0)
                                begin
                                    out_valid_next  = 1'b1;
                                    out_status_next = STAT_OK;
                                    out_found_next  = {byte_reg, pick};
                                    wr_en           = 1'b1;
                                    wr_data         = rd_data | (BYTE_W'(1) << pick);
                                    state_next      = FSM_IDLE;
                                end
                                else if (more)
                                begin
                                    out_valid_next = out_valid_reg && !rsp.ready;
                                    out_bit_next   = out_bit_reg;
                                    out_found_next = out_found_reg;
                                    addr_next      = addr_reg + 1'b1;
                                    byte_next      = next_byte[BYTE_IW-1:0];
                                    first_next     = 1'b0;
                                    rd_addr        = addr_next;
                                    rd_en          = 1'b1;
                                end
                                else
                                begin
                                    out_valid_next  = 1'b1;
                                    out_status_next = STAT_NO_FREE;
                                    state_next      = FSM_IDLE;
                                end
                            end
                            default:
                            begin
                                state_next = FSM_IDLE;
                            end
                        endcase
                    end
                end
            end

            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        pre_reg        <= pre_next;
        off_reg        <= off_next;
        end_reg        <= end_next;
        byte_reg       <= byte_next;
        addr_reg       <= addr_next;
        first_reg      <= first_next;
        out_status_reg <= out_status_next;
        out_bit_reg    <= out_bit_next;
        out_found_reg  <= out_found_next;
    end

`ifndef NO_ASSERTIONS
    a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == FSM_LOOK)
        else $error("accepted word did not start a lookup");

    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == FSM_LOOK) && (pre_reg == STAT_OK) && out_free)
        else $error("store write outside a valid lookup");

    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !req.ready)
        else $error("request taken during store sweep");

    a_alloc_result: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && (cmd_reg == CMD_ALLOC)) |=> out_valid_reg && (out_status_reg == STAT_OK))
        else $error("allocation write without ok result");
`endif

endmodule

[tb/bma_checker.sv]
module bma_checker #(
    parameter int MAP_BYTES = bma_pkg::DEF_MAP_BYTES,
    parameter int NUM_MAPS  = bma_pkg::DEF_NUM_MAPS
) (
    input  logic clk,
    input  logic rst_n,
    bma_req_if   req,
    bma_rsp_if   rsp,
    output int   fail_count,
    output int   outstanding,
    output int   words_checked,
    output int   allocs_granted,
    output int   scans_empty,
    output int   range_rejects,
    output int   conflicts
);
    import bma_pkg::*;

    localparam int MAP_BITS = MAP_BYTES * BYTE_W;

    typedef struct packed {
        status_t              status;
        logic                 bit_state;
        logic [INDEX_W-1:0]   found_index;
    } map_result_t;

    logic [BYTE_W-1:0] shadow_map [NUM_MAPS*MAP_BYTES];
    map_result_t       pending_results [$];

    function automatic map_result_t run_map_command(
        input cmd_t               cmd,
        input logic               map,
        input logic [INDEX_W-1:0] idx,
        input logic [LIMIT_W-1:0] lim
    );
        map_result_t       r;
        int                scan_end;
        int                addr;
        logic [BYTE_W-1:0] mask;
        logic              hit;
        r.status      = STAT_OK;
        r.bit_state   = 1'b0;
        r.found_index = '0;
        if (int'(map) >= NUM_MAPS)
        begin
            r.status = STAT_RANGE;
        end
        else if (cmd == CMD_ALLOC)
        begin
            scan_end = int'(lim);
            if (scan_end > MAP_BITS)
                scan_end = MAP_BITS;
            if (scan_end > INDEX_SPAN)
                scan_end = INDEX_SPAN;
            r.status = STAT_NO_FREE;
            for (int i = int'(idx); i < scan_end; i++)
            begin
                addr = int'(map) * MAP_BYTES + i / BYTE_W;
                mask = BYTE_W'(1) << (i % BYTE_W);
                if ((shadow_map[addr] & mask) == '0)
                begin
                    shadow_map[addr] = shadow_map[addr] | mask;
                    r.status         = STAT_OK;
                    r.found_index    = INDEX_W'(i);
                    break;
                end
            end
        end
        else if (int'(idx) >= int'(lim) || int'(idx) >= MAP_BITS)
        begin
            r.status = STAT_RANGE;
        end
        else
        begin
            addr = int'(map) * MAP_BYTES + int'(idx) / BYTE_W;
            mask = BYTE_W'(1) << (int'(idx) % BYTE_W);
            hit  = (shadow_map[addr] & mask) != '0;
            case (cmd)
                CMD_TEST:
                    r.bit_state = hit;
                CMD_SET:
                    if (hit)
                        r.status = STAT_ALREADY_SET;
                    else
                        shadow_map[addr] = shadow_map[addr] | mask;
                default:
                    if (!hit)
                        r.status = STAT_ALREADY_CLEAR;
                    else
                        shadow_map[addr] = shadow_map[addr] & ~mask;
            endcase
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        map_result_t got;
        map_result_t want;
        map_result_t fresh;
        if (!rst_n)
        begin
            foreach (shadow_map[a])
                shadow_map[a] = '0;
            pending_results.delete();
            fail_count     = 0;
            outstanding    = 0;
            words_checked  = 0;
            allocs_granted = 0;
            scans_empty    = 0;
            range_rejects  = 0;
            conflicts      = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.status      = rsp.status;
                got.bit_state   = rsp.bit_state;
                got.found_index = rsp.found_index;
                if (pending_results.size() == 0)
                begin
                    $error("result word with nothing pending: status %0d bit_state %0d %s %0d",
                           got.status, got.bit_state, "found_index", got.found_index);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    words_checked++;
                    if (got.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.bit_state !== want.bit_state)
                    begin
                        $error("bit_state mismatch: expected %0d, got %0d",
                               want.bit_state, got.bit_state);
                        fail_count++;
                    end
                    if (got.found_index !== want.found_index)
                    begin
                        $error("found_index mismatch: expected %0d, got %0d",
                               want.found_index, got.found_index);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                fresh = run_map_command(req.command, req.map_select, req.bit_index, req.bit_limit);
                pending_results.push_back(fresh);
                if (req.command == CMD_ALLOC && fresh.status == STAT_OK)
                    allocs_granted++;
                case (fresh.status)
                    STAT_NO_FREE:       scans_empty++;
                    STAT_RANGE:         range_rejects++;
                    STAT_ALREADY_SET,
                    STAT_ALREADY_CLEAR: conflicts++;
                    default: ;
                endcase
            end
            outstanding = pending_results.size();
        end
    end

endmodule

[tb/tb_bitmap_allocator_unit.sv]
module tb_bitmap_allocator_unit;
    import bma_pkg::*;

    localparam int MAP_BYTES  = DEF_MAP_BYTES;
    localparam int NUM_MAPS   = DEF_NUM_MAPS;
    localparam int WIN        = 32;
    localparam int SEGMENTS   = 33;
    localparam int SEG_WORDS  = 40;
    localparam int LONG_HOLD  = 400;
    localparam int HOLD_AFTER = 150;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bma_req_if req_ch ();
    bma_rsp_if rsp_ch ();

    int fail_count;
    int outstanding;
    int words_checked;
    int allocs_granted;
    int scans_empty;
    int range_rejects;
    int conflicts;

    int sent_words = 0;
    bit idle_on = 1'b0;

    always #2 clk = ~clk;

    bitmap_allocator_unit #(
        .MAP_BYTES (MAP_BYTES),
        .NUM_MAPS  (NUM_MAPS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bma_checker #(
        .MAP_BYTES (MAP_BYTES),
        .NUM_MAPS  (NUM_MAPS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .words_checked  (words_checked),
        .allocs_granted (allocs_granted),
        .scans_empty    (scans_empty),
        .range_rejects  (range_rejects),
        .conflicts      (conflicts)
    );

    // mostly back-to-back, some short gaps, rare long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(input cmd_t cmd, input logic map, input int idx, input int lim);
        int gap;
        req_ch.valid      <= 1'b1;
        req_ch.command    <= cmd;
        req_ch.map_select <= map;
        req_ch.bit_index  <= INDEX_W'(idx);
        req_ch.bit_limit  <= LIMIT_W'(lim);
        do
            @(posedge clk);
        while (!req_ch.ready);
        sent_words++;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        int gap;
        bit held;
        held = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && sent_words >= HOLD_AFTER)
            begin
                // long output stall: fills the block and backs up the request side
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end
            else
            begin
                gap = (idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
                if (gap == 0)
                begin
                    rsp_ch.ready <= 1'b1;
                end
                else
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (gap - 1) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        logic map;
        int   base;
        int   idx;
        int   lim;
        cmd_t cmd;
        req_ch.valid      = 1'b0;
        req_ch.command    = CMD_TEST;
        req_ch.map_select = 1'b0;
        req_ch.bit_index  = '0;
        req_ch.bit_limit  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_word(CMD_TEST,  1'b0, 0, 4096);
        send_word(CMD_SET,   1'b0, 0, 4096);
        send_word(CMD_SET,   1'b0, 0, 4096);
        send_word(CMD_TEST,  1'b0, 0, 4096);
        send_word(CMD_CLEAR, 1'b0, 0, 4096);
        send_word(CMD_CLEAR, 1'b0, 0, 4096);
        send_word(CMD_SET,   1'b0, 4095, 4096);
        send_word(CMD_SET,   1'b0, 4095, 4095);
        send_word(CMD_TEST,  1'b1, 0, 0);
        send_word(CMD_CLEAR, 1'b1, 4095, 8191);
        send_word(CMD_ALLOC, 1'b1, 0, 8191);
        send_word(CMD_ALLOC, 1'b1, 0, 8191);
        send_word(CMD_ALLOC, 1'b0, 4095, 4096);
        send_word(CMD_ALLOC, 1'b1, 4095, 8191);
        send_word(CMD_ALLOC, 1'b0, 10, 5);
        send_word(CMD_ALLOC, 1'b0, 0, 0);
        send_word(CMD_ALLOC, 1'b0, 4000, 4096);
        send_word(CMD_TEST,  1'b1, 4095, 4096);
        send_word(CMD_CLEAR, 1'b1, 4095, 4096);
        send_word(CMD_SET,   1'b1, 2048, 2049);
        send_word(CMD_SET,   1'b1, 2048, 2048);
        send_word(CMD_TEST,  1'b0, 4095, 8191);

        // windows of WIN bits get filled, hit and drained; the rest is noise
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            map  = 1'($urandom_range(0, 1));
            base = ($urandom_range(0, 7) == 0) ? INDEX_SPAN - WIN
                                               : $urandom_range(0, INDEX_SPAN - WIN);
            for (int k = 0; k < SEG_WORDS; k++)
            begin
                cmd = cmd_t'($urandom_range(0, 3));
                if ($urandom_range(0, 9) < 7)
                begin
                    if (cmd == CMD_ALLOC)
                        idx = base + $urandom_range(0, 3);
                    else
                        idx = base + $urandom_range(0, WIN - 1);
                    lim = ($urandom_range(0, 7) == 0) ? base + $urandom_range(0, WIN)
                                                      : base + WIN;
                    send_word(cmd, map, idx, lim);
                end
                else
                begin
                    send_word(cmd, 1'($urandom_range(0, 1)), $urandom_range(0, 4095),
                              $urandom_range(0, 8191));
                end
            end
        end
        req_ch.valid <= 1'b0;

        @(posedge clk);
        wait (outstanding == 0);
        repeat (MAP_BYTES + 16) @(posedge clk);

        $display("%0d words sent, %0d results checked: %0d allocations granted, %0d empty scans,",
                 sent_words, words_checked, allocs_granted, scans_empty);
        $display("%0d range rejects, %0d set/clear conflicts, one %0d-cycle output stall",
                 range_rejects, conflicts, LONG_HOLD);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #12000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
